/* rtl/xs256_pkg.sv */
// Shared types, constants and a helper function for the xoshiro256** generator.
package xs256_pkg;

  // Request kinds carried in the input tuser field
  localparam logic [1:0] FUNC_RAW     = 2'd0;
  localparam logic [1:0] FUNC_BOUNDED = 2'd1;
  localparam logic [1:0] FUNC_FRAC    = 2'd2;

  // splitmix64 constants
  localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

  // Shift amounts of the generator and of the fraction output
  localparam int ShiftT = 17;
  localparam int RotS3  = 45;
  localparam int FracDrop = 11;

  // Datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_INIT  = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_MIX   = 3'd4;
  localparam logic [2:0] OP_STORE = 3'd5;
  localparam logic [2:0] OP_STEP  = 3'd6;

  // Command from controller to datapath
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] idx;       // multiply step or state word index
    logic       phase;     // 0: first mix multiply, 1: second
    logic       load_req;  // capture the incoming request
    logic       load_out;  // load the result register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic reject;          // bounded draw above max_value
  } dp_status_t;

  // All-ones mask covering the highest set bit
  function automatic logic [63:0] smear64(input logic [63:0] v);
    logic [63:0] m;
    m = v;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    m = m | (m >> 32);
    return m;
  endfunction

endpackage

/* rtl/xs256_dp.sv */
// Datapath: state words, splitmix64 seeding arithmetic and result shaping.
module xs256_dp
  import xs256_pkg::*;
(
  input  logic        clk,
  input  dp_cmd_t     cmd,
  input  logic [63:0] seed,
  input  logic [1:0]  req_func,
  input  logic [63:0] req_max,
  output dp_status_t  status,
  output logic [63:0] result
);

  logic [63:0] s0, s1, s2, s3;
  logic [63:0] acc;
  logic [63:0] z;
  logic [63:0] prod;
  logic [63:0] mixacc;
  logic [63:0] t5;
  logic [1:0]  func;
  logic [63:0] maxv;
  logic [63:0] mask;

  logic [63:0] acc_sum;
  logic [63:0] mul_c;
  logic [31:0] op_a, op_b;
  logic [63:0] mul_p;
  logic [63:0] s1x5;
  logic [63:0] r9;
  logic [63:0] masked;
  logic [63:0] shaped;
  logic [63:0] mixed_out;
  logic [63:0] x13;

  // splitmix counter advance
  assign acc_sum = acc + GOLDEN_INC;

  // Shared 32x32 multiplier; three partial products form the low 64 bits
  assign mul_c = cmd.phase ? MIX_MUL_B : MIX_MUL_A;
  assign op_a  = (cmd.idx == 2'd2) ? z[63:32] : z[31:0];
  assign op_b  = (cmd.idx == 2'd1) ? mul_c[63:32] : mul_c[31:0];
  assign mul_p = op_a * op_b;

  assign mixed_out = mixacc ^ (mixacc >> 31);

  // Output scrambler: first half (x5, rotate) is registered in t5
  assign s1x5   = s1 + {s1[61:0], 2'b00};
  assign r9     = t5 + {t5[60:0], 3'b000};
  assign masked = r9 & mask;
  assign x13    = s3 ^ s1;

  always_comb begin
    case (func)
      FUNC_BOUNDED: shaped = masked;
      FUNC_FRAC:    shaped = r9 >> FracDrop;
      default:      shaped = r9;
    endcase
  end

  assign status.reject = (func == FUNC_BOUNDED) && (masked > maxv);

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func <= req_func;
      maxv <= req_max;
      mask <= smear64(req_max | 64'd1);
    end
  end

  // Seeding arithmetic
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT: acc <= seed;
      OP_ADD: begin
        acc <= acc_sum;
        z   <= acc_sum ^ (acc_sum >> 30);
      end
      OP_MUL: begin
        prod <= mul_p;
        case (cmd.idx)
          2'd0:    mixacc <= mixacc;
          2'd1:    mixacc <= prod;
          default: mixacc <= mixacc + {prod[31:0], 32'h0};
        endcase
      end
      OP_MIX: z <= mixacc ^ (mixacc >> 27);
      default: ;
    endcase
  end

  // State words: loaded by seeding, advanced by a generator step
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_STORE: begin
        case (cmd.idx)
          2'd0:    s0 <= mixed_out;
          2'd1:    s1 <= mixed_out;
          2'd2:    s2 <= mixed_out;
          default: s3 <= mixed_out;
        endcase
      end
      OP_STEP: begin
        s0 <= s0 ^ x13;
        s1 <= s1 ^ s2 ^ s0;
        s2 <= s2 ^ s0 ^ (s1 << ShiftT);
        s3 <= {x13[63-RotS3:0], x13[63:64-RotS3]};
        t5 <= {s1x5[56:0], s1x5[63:57]};
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result <= shaped;
    end
  end

endmodule

/* rtl/xs256_ctrl.sv */
// Controller: seeding sequence, request flow and output register valid.
module xs256_ctrl
  import xs256_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       seed_wr,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIN   = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_MIX   = 3'd5;
  localparam logic [2:0] ST_STORE = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] word, word_next;
  logic [1:0] k, k_next;
  logic       phase, phase_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state and datapath command
  always_comb begin
    state_next = state;
    word_next  = word;
    k_next     = k;
    phase_next = phase;
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.phase  = phase;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op       = OP_STEP;
          cmd.load_req = 1'b1;
          state_next   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.reject) begin
          cmd.op = OP_STEP;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_INIT: begin
        cmd.op     = OP_INIT;
        word_next  = 2'd0;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.op     = OP_ADD;
        phase_next = 1'b0;
        k_next     = 2'd0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.op  = OP_MUL;
        cmd.idx = k;
        k_next  = k + 2'd1;
        if (k == 2'd3) begin
          state_next = phase ? ST_STORE : ST_MIX;
        end
      end
      ST_MIX: begin
        cmd.op     = OP_MIX;
        phase_next = 1'b1;
        k_next     = 2'd0;
        state_next = ST_MUL;
      end
      ST_STORE: begin
        cmd.op     = OP_STORE;
        cmd.idx    = word;
        word_next  = word + 2'd1;
        state_next = (word == 2'd3) ? ST_IDLE : ST_ADD;
      end
      default: state_next = ST_INIT;
    endcase
    // A seed write restarts seeding
    if (seed_wr) begin
      state_next = ST_INIT;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      word      <= 2'd0;
      k         <= 2'd0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      word      <= word_next;
      k         <= k_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/xoshiro256ss_random_generator.sv */
// A result enters the output register from the FIN state once its request is
// accepted; each rejected bounded draw first takes another generator step.
// One request at a time: the next is taken only in the idle state, after the
// previous result has been loaded into a free output register.
// Reset and seed writes reload the state by four splitmix64 steps on one shared
// 32x32 multiplier, during which s_axis_tready is low.
module xoshiro256ss_random_generator
  import xs256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] bound
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic        seed_sel;
  logic        seed_wr;
  logic [63:0] seed;
  dp_cmd_t     cmd;
  dp_status_t  status;

  // Register decode: seed at byte address 0
  assign pready   = 1'b1;
  assign seed_sel = (paddr[3] == 1'b0);
  assign seed_wr  = psel && penable && pwrite && pready && seed_sel;
  assign prdata   = seed_sel ? seed : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 64'd0;
    end else if (seed_wr) begin
      seed <= pwdata;
    end
  end

  xs256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .seed_wr   (seed_wr),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  xs256_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .seed     (seed),
    .req_func (s_axis_tuser),
    .req_max  (s_axis_tdata),
    .status   (status),
    .result   (m_axis_tdata)
  );

endmodule

/* rtl/xs256_chk.sv */
// Port-level checks for the xoshiro256** generator, bound to the top level.
module xs256_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic        pready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // One request in flight: no request taken in the cycle after one
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous one in work");

  // A seed register write starts reseeding
  a_reseed: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && !paddr[3]) |=> !s_axis_tready)
    else $error("request port open right after seed write");

  // Seeding follows reset
  a_reset_seed: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_axis_tready)
    else $error("request port open right after reset");

endmodule

bind xoshiro256ss_random_generator xs256_chk u_chk (.*);

/* sim/tb.sv */
// Self-checking testbench for the xoshiro256** generator with splitmix64 seed loading.
`timescale 1ns / 1ps

module tb;
  import xs256_pkg::*;

  // Unused request code, handled by the block as a raw draw
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // splitmix64 constants for the local predictor
  localparam logic [63:0] SEED_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SEED_MUL1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SEED_MUL2 = 64'h94d049bb133111eb;

  // Register map
  localparam logic [3:0] ADDR_SEED   = 4'h0;
  localparam logic [3:0] ADDR_UNUSED = 4'h8;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1280;
  localparam int QUIET_ITEMS  = 100;
  localparam int MAX_REPORTS  = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [63:0] bound
  logic [1:0]  s_axis_tuser = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [63:0] m_axis_tdata;        // [63:0] value
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // Predictor state
  logic [63:0] gen_state [4];
  logic [63:0] seed_value;

  logic [63:0] expected_draws [$];
  int          fault_count = 0;
  int          results_checked = 0;
  int          cycle_count = 0;
  int          kind_count [4] = '{0, 0, 0, 0};
  int          seed_loads = 0;
  bit          idle_en = 1'b1;
  int          stall_left = 0;

  xoshiro256ss_random_generator dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  // Four splitmix64 outputs of the seed fill the state words
  function automatic void load_state(input logic [63:0] sd);
    logic [63:0] acc;
    logic [63:0] z;
    acc = sd;
    for (int i = 0; i < 4; i++) begin
      acc = acc + SEED_STEP;
      z = acc;
      z = (z ^ (z >> 30)) * SEED_MUL1;
      z = (z ^ (z >> 27)) * SEED_MUL2;
      gen_state[i] = z ^ (z >> 31);
    end
  endfunction

  // One xoshiro256** step; returns the scrambled output
  function automatic logic [63:0] advance_generator();
    logic [63:0] times5;
    logic [63:0] res;
    logic [63:0] t;
    times5 = gen_state[1] * 64'd5;
    res = rotl64(times5, 7) * 64'd9;
    t = gen_state[1] << 17;
    gen_state[2] = gen_state[2] ^ gen_state[0];
    gen_state[3] = gen_state[3] ^ gen_state[1];
    gen_state[1] = gen_state[1] ^ gen_state[2];
    gen_state[0] = gen_state[0] ^ gen_state[3];
    gen_state[2] = gen_state[2] ^ t;
    gen_state[3] = rotl64(gen_state[3], 45);
    return res;
  endfunction

  // Smallest all-ones mask covering the bound, at least 1
  function automatic logic [63:0] cover_mask(input logic [63:0] bound);
    logic [63:0] m;
    m = 64'd1;
    while (m < bound) m = (m << 1) | 64'd1;
    return m;
  endfunction

  function automatic logic [63:0] predict_draw(input logic [1:0] kind,
                                               input logic [63:0] bound);
    logic [63:0] mask;
    logic [63:0] r;
    case (kind)
      FUNC_BOUNDED: begin
        mask = cover_mask(bound);
        // rejected draws still advance the state
        do r = advance_generator() & mask; while (r > bound);
      end
      FUNC_FRAC: begin
        r = advance_generator() >> 11;
      end
      default: begin
        r = advance_generator();
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic note_fault(input string what, input logic [63:0] exp_v,
                            input logic [63:0] act_v);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("tb: %s: expected %h, got %h at cycle %0d", what, exp_v, act_v, cycle_count);
  endtask

  // Each result transaction is compared with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_draws.size() == 0) begin
        note_fault("result with nothing expected", '0, m_axis_tdata);
      end else begin
        if (m_axis_tdata !== expected_draws[0])
          note_fault("value mismatch", expected_draws[0], m_axis_tdata);
        void'(expected_draws.pop_front());
        results_checked++;
      end
    end
  end

  // Random stall bursts on the result side
  always @(posedge clk) begin
    if (!idle_en) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_draws.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One request transaction; tvalid stays high so the next call can follow back to back
  task automatic send_request(input logic [1:0] kind, input logic [63:0] bound);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bound;
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_draws.push_back(predict_draw(kind, bound));
    kind_count[kind]++;
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup and access phase; the register takes the data at the access edge
  task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_SEED) begin
      seed_value = data;
      load_state(seed_value);
      seed_loads++;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Bound with a spread of magnitudes, extremes included
  function automatic logic [63:0] rand_bound();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return rand64() >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [1:0] rand_kind();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return FUNC_RAW;
    if (pick < 7) return FUNC_BOUNDED;
    if (pick < 9) return FUNC_FRAC;
    return FUNC_SPARE;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // State loaded from the reset seed, including the spare request code
  task automatic test_reset_seed();
    send_request(FUNC_RAW, '0);
    send_request(FUNC_RAW, '1);
    send_request(FUNC_SPARE, rand64());
    drain_results();
  endtask

  // Bounded, fraction and spare request kinds and the bound extremes
  task automatic test_request_kinds();
    send_request(FUNC_BOUNDED, 64'd0);
    send_request(FUNC_BOUNDED, '1);
    send_request(FUNC_BOUNDED, 64'd1);
    send_request(FUNC_BOUNDED, 64'h8000_0000_0000_0000);
    send_request(FUNC_BOUNDED, 64'd5);
    send_request(FUNC_FRAC, '1);
    send_request(FUNC_FRAC, '0);
    send_request(FUNC_SPARE, '1);
    drain_results();
  endtask

  // Seed writes at the extremes, plus a write to an unmapped index
  task automatic test_seed_loads();
    reg_write(ADDR_SEED, '1);
    send_request(FUNC_RAW, rand64());
    send_request(FUNC_BOUNDED, 64'd100);
    send_request(FUNC_FRAC, rand64());
    drain_results();
    reg_write(ADDR_SEED, '0);
    send_request(FUNC_RAW, rand64());
    send_request(FUNC_BOUNDED, 64'd0);
    drain_results();
    reg_write(ADDR_UNUSED, rand64());
    send_request(FUNC_RAW, rand64());
    send_request(FUNC_FRAC, rand64());
    drain_results();
    reg_write(ADDR_SEED, rand64());
    send_request(FUNC_RAW, rand64());
    send_request(FUNC_BOUNDED, rand_bound());
    drain_results();
  endtask

  // Mixed traffic with reseeds between phases and varying idle pressure
  task automatic test_random_traffic();
    logic [63:0] sd;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) idle_en = ($urandom_range(0, 3) != 0);
      if (n % 200 == 199) begin
        drain_results();
        case ($urandom_range(0, 3))
          0:       sd = '0;
          1:       sd = '1;
          default: sd = rand64();
        endcase
        reg_write(ADDR_SEED, sd);
        if ($urandom_range(0, 3) == 0) reg_write(ADDR_UNUSED, rand64());
      end
      send_request(rand_kind(), rand_bound());
    end
    drain_results();
    idle_en = 1'b1;
  endtask

  // Back-to-back requests with no idling on either side
  task automatic test_steady_stream();
    idle_en = 1'b0;
    reg_write(ADDR_SEED, rand64());
    for (int n = 0; n < QUIET_ITEMS; n++) send_request(rand_kind(), rand_bound());
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    seed_value = '0;
    load_state(seed_value);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_seed();
    test_request_kinds();
    test_seed_loads();
    test_random_traffic();
    test_steady_stream();

    $display("tb: %0d requests (raw %0d, bounded %0d, fraction %0d, spare code %0d)",
             kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
             kind_count[FUNC_RAW], kind_count[FUNC_BOUNDED], kind_count[FUNC_FRAC],
             kind_count[FUNC_SPARE]);
    $display("tb: %0d seed loads, %0d results checked, %0d faults",
             seed_loads, results_checked, fault_count);
    if (fault_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
